@@ rtl/core/hse_pkg.sv @@
`default_nettype none

package hse_pkg;

    // Default sizes of the element store.
    localparam int STORE_DEPTH_DEF   = 64;
    localparam int ELEMENT_WIDTH_DEF = 32;

    // Fixed widths of the channel payloads and of the register port.
    localparam int VALUE_WIDTH    = 32;
    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;

    // The register index is the word address bit of paddr.
    localparam logic CFG_IDX_COMPARE_SIGNED = 1'b0;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load;      // store the incoming element or flag an overflow
        logic start;     // latch heap size and build index from the count, clear the output index
        logic bld_rd;    // read the element at the build index
        logic bld_ld;    // take that element as the one to sift
        logic sift_rd;   // read both children of the current position
        logic sift_cmp;  // compare, then move one level down or place the held element
        logic l_dec;     // step the build index back by one
        logic ext_rd;    // read the root and the last heap entry
        logic ext_wr;    // move the root to the end and shrink the heap
        logic out_rd;    // read the next sorted element
        logic out_adv;   // advance the output index
        logic clear;     // empty the store for the next set
    } hse_cmd_t;

    // Status from the datapath back to the sequencer.
    typedef struct packed {
        logic cnt_gt1;   // more than one element stored
        logic leaf;      // current position has no children
        logic stop;      // held element is not below the larger child
        logic l_one;     // build index is at the root
        logic n_gt1;     // heap still holds more than one entry
        logic last_k;    // output index points at the last element
    } hse_status_t;

endpackage

`default_nettype wire

@@ rtl/core/hse_ifs.sv @@
`default_nettype none

interface hse_in_if;
    logic                              valid;
    logic                              ready;
    logic [hse_pkg::VALUE_WIDTH-1:0]   element;
    logic                              final_req;

    modport source (output valid, output element, output final_req, input ready);
    modport sink   (input valid, input element, input final_req, output ready);
endinterface

interface hse_out_if;
    logic                              valid;
    logic                              ready;
    logic [hse_pkg::VALUE_WIDTH-1:0]   sorted_value;
    logic                              end_of_run;
    logic                              dropped;

    modport source (output valid, output sorted_value, output end_of_run, output dropped,
                    input ready);
    modport sink   (input valid, input sorted_value, input end_of_run, input dropped,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/heapsort_engine_unit.sv @@
// Heapsort engine: collects a set of elements and returns them in ascending order.
// Input channel in_ch: one element per transaction; final_req marks the last
// element of the set. Elements past STORE_DEPTH are discarded and every result of
// that set carries dropped. Output channel out_ch: one sorted element per
// transaction, end_of_run on the last one. The APB register compare_signed
// (address 0) selects two's complement or unsigned order; write it while idle.
// During loading the input is ready in every cycle. After the final element a setup
// step follows, then the heap build, where each of the n/2 steps fetches its element,
// sifts it down level by level and finishes by writing it in place. Then extraction:
// each of the n-1 steps swaps the root to the end and then sifts the same way. The
// single store memory with two read ports and one write port shapes these steps:
// each sift level is one read and one compare-and-write. Output reads each element
// and then offers it. The input is not ready from the final element until the last
// result is taken. A stalled output holds its transaction unchanged and the engine
// waits. Reset empties the set, clears the overflow flag and sets compare_signed to
// unsigned; store contents are not cleared and need no clearing pass.
`default_nettype none

module heapsort_engine_unit #(
    parameter int STORE_DEPTH   = hse_pkg::STORE_DEPTH_DEF,
    parameter int ELEMENT_WIDTH = hse_pkg::ELEMENT_WIDTH_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    hse_in_if.sink                               in_ch,
    hse_out_if.source                            out_ch,
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire  [hse_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  wire  [hse_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic [hse_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                 pready
);

    logic                 cmp_signed_reg;
    logic                 cfg_sel;
    hse_pkg::hse_cmd_t    cmd;
    hse_pkg::hse_status_t status;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[hse_pkg::APB_ADDR_WIDTH-1] == hse_pkg::CFG_IDX_COMPARE_SIGNED);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmp_signed_reg <= 1'b0;
        else if (psel && penable && pwrite && pready && cfg_sel)
            cmp_signed_reg <= pwdata[0];
    end

    always_comb
    begin
        prdata = '0;
        if (cfg_sel)
            prdata[0] = cmp_signed_reg;
    end

    hse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .final_req (in_ch.final_req),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    hse_dpath #(
        .STORE_DEPTH   (STORE_DEPTH),
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cmp_signed   (cmp_signed_reg),
        .element      (in_ch.element),
        .sorted_value (out_ch.sorted_value),
        .end_of_run   (out_ch.end_of_run),
        .dropped      (out_ch.dropped)
    );

endmodule

`default_nettype wire

@@ rtl/core/hse_ctrl.sv @@
`default_nettype none

module hse_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    input  wire                  final_req,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire                  out_ready,
    input  hse_pkg::hse_status_t status,
    output hse_pkg::hse_cmd_t    cmd
);

    localparam logic [3:0] ST_LOAD     = 4'd0;
    localparam logic [3:0] ST_START    = 4'd1;
    localparam logic [3:0] ST_BLD_RD   = 4'd2;
    localparam logic [3:0] ST_BLD_LD   = 4'd3;
    localparam logic [3:0] ST_SIFT_RD  = 4'd4;
    localparam logic [3:0] ST_SIFT_CMP = 4'd5;
    localparam logic [3:0] ST_EXT_RD   = 4'd6;
    localparam logic [3:0] ST_EXT_WR   = 4'd7;
    localparam logic [3:0] ST_OUT_RD   = 4'd8;
    localparam logic [3:0] ST_OUT      = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       phase_ext_reg;
    logic       phase_ext_next;
    logic [3:0] sift_done_state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            phase_ext_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_ext_reg <= phase_ext_next;
        end
    end

    // Where a finished sift continues: the next build step, the next
    // extraction, or the output once the heap is down to one entry.
    always_comb
    begin
        if (phase_ext_reg)
            sift_done_state = status.n_gt1 ? ST_EXT_RD : ST_OUT_RD;
        else
            sift_done_state = status.l_one ? ST_EXT_RD : ST_BLD_RD;
    end

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        phase_ext_next = phase_ext_reg;
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (final_req)
                        state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.start      = 1'b1;
                phase_ext_next = 1'b0;
                state_next     = status.cnt_gt1 ? ST_BLD_RD : ST_OUT_RD;
            end
            ST_BLD_RD:
            begin
                cmd.bld_rd = 1'b1;
                state_next = ST_BLD_LD;
            end
            ST_BLD_LD:
            begin
                cmd.bld_ld = 1'b1;
                state_next = ST_SIFT_RD;
            end
            ST_SIFT_RD:
            begin
                cmd.sift_rd = 1'b1;
                if (status.leaf)
                begin
                    cmd.l_dec  = !phase_ext_reg;
                    state_next = sift_done_state;
                end
                else
                begin
                    state_next = ST_SIFT_CMP;
                end
            end
            ST_SIFT_CMP:
            begin
                cmd.sift_cmp = 1'b1;
                if (status.stop)
                begin
                    cmd.l_dec  = !phase_ext_reg;
                    state_next = sift_done_state;
                end
                else
                begin
                    state_next = ST_SIFT_RD;
                end
            end
            ST_EXT_RD:
            begin
                cmd.ext_rd = 1'b1;
                state_next = ST_EXT_WR;
            end
            ST_EXT_WR:
            begin
                cmd.ext_wr     = 1'b1;
                phase_ext_next = 1'b1;
                state_next     = ST_SIFT_RD;
            end
            ST_OUT_RD:
            begin
                cmd.out_rd = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.last_k)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        cmd.out_adv = 1'b1;
                        state_next  = ST_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/hse_dpath.sv @@
`default_nettype none

module hse_dpath #(
    parameter int STORE_DEPTH   = hse_pkg::STORE_DEPTH_DEF,
    parameter int ELEMENT_WIDTH = hse_pkg::ELEMENT_WIDTH_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  hse_pkg::hse_cmd_t                  cmd,
    output hse_pkg::hse_status_t               status,
    input  wire                                cmp_signed,
    input  wire  [hse_pkg::VALUE_WIDTH-1:0]    element,
    output logic [hse_pkg::VALUE_WIDTH-1:0]    sorted_value,
    output logic                               end_of_run,
    output logic                               dropped
);

    localparam int VW = hse_pkg::VALUE_WIDTH;
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int PW = CW + 1;

    logic [ELEMENT_WIDTH-1:0] store_mem [STORE_DEPTH];

    logic [CW-1:0]            count_reg;
    logic                     overflow_reg;
    logic [CW-1:0]            n_reg;
    logic [CW-1:0]            l_reg;
    logic [CW-1:0]            i_reg;
    logic [CW-1:0]            k_reg;
    logic [ELEMENT_WIDTH-1:0] hold_reg;
    logic [ELEMENT_WIDTH-1:0] rd_a_reg;
    logic [ELEMENT_WIDTH-1:0] rd_b_reg;

    logic [ELEMENT_WIDTH-1:0] elem_in;
    logic [PW-1:0]            j_pos;
    logic [PW-1:0]            j_m1;
    logic [PW-1:0]            n_ext;
    logic [PW-1:0]            c_pos;
    logic [CW-1:0]            i_m1;
    logic [CW-1:0]            l_m1;
    logic [CW-1:0]            n_m1;
    logic                     full;
    logic                     two_kids;
    logic                     take_b;
    logic [ELEMENT_WIDTH-1:0] c_val;
    logic                     stop;
    logic                     rd_en;
    logic [AW-1:0]            rd_a_addr;
    logic [AW-1:0]            rd_b_addr;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [ELEMENT_WIDTH-1:0] wr_data;

    // Strict order; signed mode flips the sign bit and compares unsigned.
    function automatic logic less_f(input logic [ELEMENT_WIDTH-1:0] x,
                                    input logic [ELEMENT_WIDTH-1:0] y,
                                    input logic                     sgn);
        logic [ELEMENT_WIDTH-1:0] flip;
        flip                    = '0;
        flip[ELEMENT_WIDTH-1]   = sgn;
        return (x ^ flip) < (y ^ flip);
    endfunction

    assign elem_in = ELEMENT_WIDTH'(element);

    // Heap positions are 1-based; store index is position minus one.
    assign j_pos    = {i_reg, 1'b0};
    assign j_m1     = j_pos - PW'(1);
    assign n_ext    = {1'b0, n_reg};
    assign i_m1     = i_reg - CW'(1);
    assign l_m1     = l_reg - CW'(1);
    assign n_m1     = n_reg - CW'(1);
    assign full     = (count_reg == CW'(STORE_DEPTH));
    assign two_kids = (j_pos < n_ext);
    assign take_b   = two_kids && less_f(rd_a_reg, rd_b_reg, cmp_signed);
    assign c_val    = take_b ? rd_b_reg : rd_a_reg;
    assign c_pos    = take_b ? (j_pos + PW'(1)) : j_pos;
    assign stop     = !less_f(hold_reg, c_val, cmp_signed);

    assign status.cnt_gt1 = (count_reg > CW'(1));
    assign status.leaf    = (j_pos > n_ext);
    assign status.stop    = stop;
    assign status.l_one   = (l_reg == CW'(1));
    assign status.n_gt1   = (n_reg > CW'(1));
    assign status.last_k  = (k_reg == count_reg - CW'(1));

    assign sorted_value = VW'(rd_a_reg);
    assign end_of_run   = status.last_k;
    assign dropped      = overflow_reg;

    always_comb
    begin
        rd_en     = cmd.bld_rd | cmd.sift_rd | cmd.ext_rd | cmd.out_rd;
        rd_a_addr = '0;
        rd_b_addr = '0;
        if (cmd.bld_rd)
        begin
            rd_a_addr = l_m1[AW-1:0];
        end
        else if (cmd.sift_rd)
        begin
            rd_a_addr = j_m1[AW-1:0];
            rd_b_addr = j_pos[AW-1:0];
        end
        else if (cmd.ext_rd)
        begin
            rd_a_addr = n_m1[AW-1:0];
        end
        else if (cmd.out_rd)
        begin
            rd_a_addr = k_reg[AW-1:0];
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = i_m1[AW-1:0];
        wr_data = hold_reg;
        if (cmd.load)
        begin
            wr_en   = !full;
            wr_addr = count_reg[AW-1:0];
            wr_data = elem_in;
        end
        else if (cmd.sift_rd)
        begin
            wr_en = status.leaf;
        end
        else if (cmd.sift_cmp)
        begin
            wr_en   = 1'b1;
            wr_data = stop ? hold_reg : c_val;
        end
        else if (cmd.ext_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = n_m1[AW-1:0];
            wr_data = rd_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_a_reg <= store_mem[rd_a_addr];
            rd_b_reg <= store_mem[rd_b_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else if (cmd.clear)
        begin
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            if (full)
                overflow_reg <= 1'b1;
            else
                count_reg <= count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            n_reg <= count_reg;
            l_reg <= count_reg >> 1;
            k_reg <= '0;
        end
        if (cmd.l_dec)
            l_reg <= l_m1;
        if (cmd.bld_ld)
        begin
            hold_reg <= rd_a_reg;
            i_reg    <= l_reg;
        end
        if (cmd.sift_cmp && !stop)
            i_reg <= c_pos[CW-1:0];
        if (cmd.ext_wr)
        begin
            hold_reg <= rd_a_reg;
            n_reg    <= n_m1;
            i_reg    <= CW'(1);
        end
        if (cmd.out_adv)
            k_reg <= k_reg + CW'(1);
    end

endmodule

`default_nettype wire

@@ rtl/core/hse_checker.sv @@
`default_nettype none

module hse_checker (
    input wire                               clk,
    input wire                               rst_n,
    input wire                               in_valid,
    input wire                               in_ready,
    input wire                               in_final,
    input wire                               out_valid,
    input wire                               out_ready,
    input wire [hse_pkg::VALUE_WIDTH-1:0]    out_value,
    input wire                               out_eor,
    input wire                               out_dropped
);

    // The engine either collects or emits, never both at once.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is offered");

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_value)
                                       && $stable(out_eor) && $stable(out_dropped)))
        else $error("stalled result changed");

    // Closing a set stops intake until its results are out.
    a_final_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_final) |=> !in_ready)
        else $error("input taken after the final element");

    // The last result of a set returns the engine to collecting.
    a_run_reopens: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_eor) |=> in_ready)
        else $error("engine not ready after end of run");

    // Within a run the overflow flag stays the same from result to result.
    a_drop_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_eor) |=> ##1 (out_valid
                                                  && out_dropped == $past(out_dropped, 2)))
        else $error("dropped flag changed within a run");

endmodule

bind heapsort_engine_unit hse_checker u_hse_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_final    (in_ch.final_req),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_value   (out_ch.sorted_value),
    .out_eor     (out_ch.end_of_run),
    .out_dropped (out_ch.dropped)
);

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;

    localparam int VALUE_WIDTH    = hse_pkg::VALUE_WIDTH;
    localparam int APB_ADDR_WIDTH = hse_pkg::APB_ADDR_WIDTH;
    localparam int APB_DATA_WIDTH = hse_pkg::APB_DATA_WIDTH;
    localparam int DEPTH = hse_pkg::STORE_DEPTH_DEF;
    localparam int EW    = hse_pkg::ELEMENT_WIDTH_DEF;
    localparam logic [VALUE_WIDTH-1:0] ELEM_MASK  = {VALUE_WIDTH{1'b1}} >> (VALUE_WIDTH - EW);
    localparam logic [VALUE_WIDTH-1:0] ORDER_FLIP = 1 << (EW - 1);
    localparam logic [APB_ADDR_WIDTH-1:0] ADDR_COMPARE =
        {hse_pkg::CFG_IDX_COMPARE_SIGNED, 2'b00};
    localparam logic [APB_ADDR_WIDTH-1:0] ADDR_UNUSED  = 3'b100;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct {
        logic [VALUE_WIDTH-1:0] sorted_value;
        logic                   end_of_run;
        logic                   dropped;
    } sorted_item_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_WIDTH-1:0] paddr;
    logic [APB_DATA_WIDTH-1:0] pwdata;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic pready;

    hse_in_if  in_ch ();
    hse_out_if out_ch ();

    heapsort_engine_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the engine: the set being collected and the compare order.
    logic [VALUE_WIDTH-1:0] set_elems [DEPTH];
    int                     set_count;
    logic                   set_overflow;
    logic                   order_signed;
    sorted_item_t           sorted_due [$];

    int  fail_count;
    int  results_checked;
    int  sets_sorted;
    int  signed_sets;
    int  overflow_sets;
    int  cycle_count;
    bit  idle_on;
    int  hold_left;
    int  stall_left;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic flag_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("MISMATCH: %s", msg);
    endtask

    // Collects one element and, on the final one, sorts the set and queues the results.
    task automatic collect_and_sort(input logic [VALUE_WIDTH-1:0] value, input logic fin);
        logic [VALUE_WIDTH-1:0] keys [DEPTH];
        logic [VALUE_WIDTH-1:0] k;
        logic [VALUE_WIDTH-1:0] flip;
        sorted_item_t           item;
        int                     i;
        int                     j;
        if (set_count < DEPTH)
        begin
            set_elems[set_count] = value & ELEM_MASK;
            set_count++;
        end
        else
            set_overflow = 1'b1;
        if (fin)
        begin
            // The signed order is the unsigned order with the sign bit inverted.
            flip = order_signed ? ORDER_FLIP : '0;
            for (i = 0; i < set_count; i++)
            begin
                k = set_elems[i] ^ flip;
                j = i;
                while (j > 0 && keys[j - 1] > k)
                begin
                    keys[j] = keys[j - 1];
                    j--;
                end
                keys[j] = k;
            end
            for (i = 0; i < set_count; i++)
            begin
                item.sorted_value = keys[i] ^ flip;
                item.end_of_run   = (i == set_count - 1);
                item.dropped      = set_overflow;
                sorted_due.push_back(item);
            end
            sets_sorted++;
            if (order_signed)
                signed_sets++;
            if (set_overflow)
                overflow_sets++;
            set_count    = 0;
            set_overflow = 1'b0;
        end
    endtask

    task automatic send_element(input logic [VALUE_WIDTH-1:0] value, input logic fin);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.element   <= value;
        in_ch.final_req <= fin;
        do
            @(posedge clk);
        while (!in_ch.ready);
        collect_and_sort(value, fin);
    endtask

    function automatic logic [VALUE_WIDTH-1:0] pick_element();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000 ^ $urandom_range(0, 3);
            3: return $urandom_range(0, 15);
            4: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_set(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_element(pick_element(), i == n - 1);
    endtask

    // Waits for every queued result, then lets the engine clear.
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sorted_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_WIDTH-1:0] addr,
                             input logic [APB_DATA_WIDTH-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_COMPARE)
            order_signed = data[0];
    endtask

    task automatic apb_check(input logic [APB_ADDR_WIDTH-1:0] addr);
        logic [APB_DATA_WIDTH-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        want = {{(APB_DATA_WIDTH - 1){1'b0}}, order_signed};
        if (prdata !== want)
            flag_mismatch($sformatf("compare_signed read back %h, expected %h", prdata, want));
    endtask

    task automatic set_order(input logic s);
        apb_write(ADDR_COMPARE, {31'($urandom_range(0, 32'h7FFF_FFFF)), s});
    endtask

    task automatic test_register_access();
        apb_check(ADDR_COMPARE);
        apb_write(ADDR_UNUSED, '1);
        apb_check(ADDR_COMPARE);
        apb_write(ADDR_COMPARE, 32'hFFFF_FFFF);
        apb_check(ADDR_COMPARE);
        apb_write(ADDR_COMPARE, 32'hFFFF_FFFE);
        apb_check(ADDR_COMPARE);
    endtask

    task automatic send_extremes();
        send_element(32'h0000_0000, 1'b0);
        send_element(32'hFFFF_FFFF, 1'b0);
        send_element(32'h8000_0000, 1'b0);
        send_element(32'h7FFF_FFFF, 1'b0);
        send_element(32'h0000_0001, 1'b0);
        send_element(32'h8000_0000, 1'b0);
        send_element(32'h0000_0000, 1'b1);
    endtask

    task automatic test_unsigned_order();
        set_order(1'b0);
        send_extremes();
        // A set of one element is closed by its only item.
        send_element(32'hA5A5_5A5A, 1'b1);
        send_element(32'h0000_0005, 1'b0);
        send_element(32'h0000_0005, 1'b0);
        send_element(32'h0000_0005, 1'b1);
        settle();
    endtask

    task automatic test_signed_order();
        set_order(1'b1);
        apb_check(ADDR_COMPARE);
        send_extremes();
        send_element(32'h0000_0000, 1'b0);
        send_element(32'hFFFF_FFFF, 1'b1);
        settle();
    endtask

    task automatic test_random_sets(input int budget);
        int sent;
        int n;
        sent = 0;
        while (sent < budget)
        begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
            send_random_set(n);
            sent += n;
            if ($urandom_range(0, 2) == 0)
            begin
                settle();
                if ($urandom_range(0, 4) == 0)
                    apb_write(ADDR_UNUSED, $urandom);
                set_order($urandom_range(0, 1));
            end
        end
        settle();
    endtask

    // The final element lands in the last free entry, so nothing is dropped.
    task automatic test_full_store();
        set_order($urandom_range(0, 1));
        send_random_set(DEPTH);
        settle();
    endtask

    // The final element arrives with the store already full and is discarded.
    task automatic test_store_overflow();
        set_order($urandom_range(0, 1));
        send_random_set(DEPTH + $urandom_range(1, 3));
        settle();
    endtask

    // The receiver holds off while a second set queues up behind the first.
    task automatic test_output_backpressure();
        hold_left = 400;
        send_random_set(6);
        send_random_set(6);
        settle();
    endtask

    task automatic test_no_idle_tail();
        idle_on = 1'b0;
        test_random_sets(20);
    endtask

    // Output receiver: random stall bursts plus the long hold-off on request.
    initial
    begin
        out_ch.ready = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 16);
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Each result transaction is compared with the oldest queued expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (sorted_due.size() == 0)
                flag_mismatch($sformatf("unexpected result value=%h end=%b dropped=%b",
                                        out_ch.sorted_value, out_ch.end_of_run,
                                        out_ch.dropped));
            else
            begin
                if (out_ch.sorted_value !== sorted_due[0].sorted_value
                    || out_ch.end_of_run !== sorted_due[0].end_of_run
                    || out_ch.dropped !== sorted_due[0].dropped)
                    flag_mismatch($sformatf(
                        "expected value=%h end=%b dropped=%b, got value=%h end=%b dropped=%b",
                        sorted_due[0].sorted_value, sorted_due[0].end_of_run,
                        sorted_due[0].dropped, out_ch.sorted_value, out_ch.end_of_run,
                        out_ch.dropped));
                void'(sorted_due.pop_front());
                results_checked++;
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding.",
                 cycle_count, sorted_due.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.element   = '0;
        in_ch.final_req = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        set_count       = 0;
        set_overflow    = 1'b0;
        order_signed    = 1'b0;
        fail_count      = 0;
        results_checked = 0;
        sets_sorted     = 0;
        signed_sets     = 0;
        overflow_sets   = 0;
        idle_on         = 1'b1;
        hold_left       = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_access();
        test_unsigned_order();
        test_signed_order();
        test_random_sets(25);
        test_full_store();
        test_store_overflow();
        test_output_backpressure();
        test_no_idle_tail();

        in_ch.valid <= 1'b0;
        while (sorted_due.size() != 0)
            @(posedge clk);
        repeat (32) @(posedge clk);
        if (sorted_due.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", sorted_due.size()));

        $display("Sorted %0d sets (%0d in signed order, %0d with dropped elements),",
                 sets_sorted, signed_sets, overflow_sets);
        $display("checked %0d results, %0d mismatches.", results_checked, fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
